>>> hdl/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative cache tag store model.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W        = 64;
  localparam int COUNT_W       = 32;
  localparam int OUTCOME_W     = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 6;
  localparam int SET_BITS_W    = 3;
  localparam int OFFSET_BITS_W = 6;
  localparam int WAYS_W        = 4;

  localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 3'd4;
  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]        WAYS_RST        = 4'd1;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_STAMP_WIDTH  = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_WRITE
  } state_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS        = 2'd2
  } cfg_reg_t;

endpackage

>>> hdl/sacl_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ifs
// Valid/ready channel interfaces for addresses, results and register writes.
// ----------------------------------------------------------------------------
interface sacl_in_if;
  logic                       valid;
  logic                       ready;
  logic [sacl_pkg::ADDR_W-1:0] access_address;

  modport source (output valid, output access_address, input ready);
  modport sink   (input valid, input access_address, output ready);
endinterface

interface sacl_out_if;
  logic                          valid;
  logic                          ready;
  logic [sacl_pkg::OUTCOME_W-1:0] outcome;
  logic [sacl_pkg::COUNT_W-1:0]   hit_total;
  logic [sacl_pkg::COUNT_W-1:0]   miss_total;
  logic [sacl_pkg::COUNT_W-1:0]   evict_total;

  modport source (output valid, output outcome, output hit_total, output miss_total,
                  output evict_total, input ready);
  modport sink   (input valid, input outcome, input hit_total, input miss_total,
                  input evict_total, output ready);
endinterface

interface sacl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sacl_pkg::CFG_IDX_W-1:0]  index;
  logic [sacl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/sacl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4,
  parameter int DEPTH  = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/sacl_way_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_way_select
// Tag compare, newest stamp and least-recently-used victim search for one set.
// ----------------------------------------------------------------------------
module sacl_way_select #(
  parameter int MAX_WAYS    = sacl_pkg::DEF_MAX_WAYS,
  parameter int STAMP_WIDTH = sacl_pkg::DEF_STAMP_WIDTH,
  localparam int LINE_W     = 1 + sacl_pkg::ADDR_W + STAMP_WIDTH,
  localparam int ROW_W      = MAX_WAYS * LINE_W,
  localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic [ROW_W-1:0]            row,
  input  logic [sacl_pkg::ADDR_W-1:0] tag,
  input  logic [MAX_WAYS-1:0]         way_en,
  output sacl_pkg::outcome_t          outcome,
  output logic [WAY_W-1:0]            sel_way,
  output logic [STAMP_WIDTH-1:0]      fresh
);

  localparam int LEAVES = 1 << WAY_W;

  logic [LEAVES*LINE_W-1:0] row_pad;
  logic [LEAVES-1:0]        en_pad;
  logic [STAMP_WIDTH-1:0]   mx     [1:2*LEAVES-1];
  logic                     mn_en  [1:2*LEAVES-1];
  logic [STAMP_WIDTH-1:0]   mn_st  [1:2*LEAVES-1];
  logic [WAY_W-1:0]         mn_idx [1:2*LEAVES-1];
  logic                     hit;
  logic [WAY_W-1:0]         hit_way;
  logic                     empty;
  logic [WAY_W-1:0]         empty_way;

  assign row_pad = (LEAVES*LINE_W)'(row);
  assign en_pad  = LEAVES'(way_en);

  // Registered-free trees: maximum stamp, and minimum stamp with ties to the lower way.
  always_comb begin
    for (int i = LEAVES; i < 2 * LEAVES; i++) begin
      mn_en[i]  = en_pad[i-LEAVES];
      mn_st[i]  = row_pad[(i-LEAVES)*LINE_W +: STAMP_WIDTH];
      mn_idx[i] = WAY_W'(i - LEAVES);
      mx[i]     = en_pad[i-LEAVES] ? row_pad[(i-LEAVES)*LINE_W +: STAMP_WIDTH] : '0;
    end
    for (int i = LEAVES - 1; i >= 1; i--) begin
      mx[i] = (mx[2*i] >= mx[2*i+1]) ? mx[2*i] : mx[2*i+1];
      if (mn_en[2*i] && (!mn_en[2*i+1] || mn_st[2*i] <= mn_st[2*i+1])) begin
        mn_en[i]  = mn_en[2*i];
        mn_st[i]  = mn_st[2*i];
        mn_idx[i] = mn_idx[2*i];
      end else begin
        mn_en[i]  = mn_en[2*i+1];
        mn_st[i]  = mn_st[2*i+1];
        mn_idx[i] = mn_idx[2*i+1];
      end
    end
  end

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    empty     = 1'b0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (way_en[w] && row[w*LINE_W + LINE_W - 1] &&
          row[w*LINE_W + STAMP_WIDTH +: sacl_pkg::ADDR_W] == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (way_en[w] && !row[w*LINE_W + LINE_W - 1]) begin
        empty     = 1'b1;
        empty_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    if (hit) begin
      outcome = sacl_pkg::OUT_HIT;
      sel_way = hit_way;
    end else if (empty) begin
      outcome = sacl_pkg::OUT_FILL;
      sel_way = empty_way;
    end else begin
      outcome = sacl_pkg::OUT_EVICT;
      sel_way = mn_idx[1];
    end
  end

  assign fresh = (mx[1] == '1) ? mx[1] : mx[1] + 1'b1;

endmodule

>>> hdl/set_assoc_cache_lru_sim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Tag store of a set-associative cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Payload                                   | Transfer
//  in_chan   | in        | access_address                            | valid & ready
//  out_chan  | out       | outcome, hit_total, miss_total, evict_total | valid & ready
//  cfg_chan  | in        | index, data                               | valid & ready
//
// For each address the set row is read from the tag RAM in the cycle of the
// transfer, compared and searched in the next (ST_LOOK), and written back in
// ST_WRITE, when the result enters the output register.
// After reset a clearing pass writes every row of the tag RAM, during which no
// address is accepted.
// Write-back waits while the output register holds a result that is not taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
  parameter int STAMP_WIDTH  = sacl_pkg::DEF_STAMP_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  sacl_in_if.sink      in_chan,
  sacl_out_if.source   out_chan,
  sacl_cfg_if.sink     cfg_chan
);

  localparam int SET_AW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH     = 1 << SET_AW;
  localparam int LINE_W    = 1 + sacl_pkg::ADDR_W + STAMP_WIDTH;
  localparam int ROW_W     = MAX_WAYS * LINE_W;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW       = ($clog2(MAX_WAYS + 1) > sacl_pkg::WAYS_W) ?
                             $clog2(MAX_WAYS + 1) : sacl_pkg::WAYS_W;
  localparam int SET_CLAMP = (MAX_SET_BITS > 7) ? 7 : MAX_SET_BITS;
  localparam int TOTAL_W   = sacl_pkg::OFFSET_BITS_W + 1;

  sacl_pkg::state_t state_r, state_nxt;

  logic [sacl_pkg::SET_BITS_W-1:0]    set_bits_r;
  logic [sacl_pkg::OFFSET_BITS_W-1:0] offset_bits_r;
  logic [sacl_pkg::WAYS_W-1:0]        ways_r;

  logic [SET_AW-1:0]           clr_cnt_r;
  logic [SET_AW-1:0]           set_r;
  logic [sacl_pkg::ADDR_W-1:0] tag_r;
  logic [MAX_WAYS-1:0]         way_en_r;
  sacl_pkg::outcome_t          outcome_r;
  logic [WAY_W-1:0]            sel_way_r;
  logic [STAMP_WIDTH-1:0]      fresh_r;

  logic [sacl_pkg::COUNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [sacl_pkg::COUNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [sacl_pkg::COUNT_W-1:0] evict_cnt_r, evict_cnt_nxt;

  logic                          out_valid_r;
  sacl_pkg::outcome_t            out_outcome_r;
  logic [sacl_pkg::COUNT_W-1:0]  out_hit_r;
  logic [sacl_pkg::COUNT_W-1:0]  out_miss_r;
  logic [sacl_pkg::COUNT_W-1:0]  out_evict_r;

  logic                          in_take;
  logic                          slot_free;
  logic                          issue;
  logic                          ram_we;
  logic [SET_AW-1:0]             ram_waddr;
  logic [ROW_W-1:0]              ram_wdata;
  logic [ROW_W-1:0]              ram_rdata;
  logic [ROW_W-1:0]              new_row;

  logic [sacl_pkg::SET_BITS_W-1:0] s_eff;
  logic [TOTAL_W-1:0]              total_bits;
  logic [sacl_pkg::ADDR_W-1:0]     tag_w;
  logic [sacl_pkg::ADDR_W-1:0]     set_mask;
  logic [SET_AW-1:0]               set_w;
  logic [WCW-1:0]                  ways_eff;
  logic [MAX_WAYS-1:0]             way_en_w;

  sacl_pkg::outcome_t     sel_outcome;
  logic [WAY_W-1:0]       sel_way;
  logic [STAMP_WIDTH-1:0] sel_fresh;

  // Configuration registers.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= sacl_pkg::SET_BITS_RST;
      offset_bits_r <= sacl_pkg::OFFSET_BITS_RST;
      ways_r        <= sacl_pkg::WAYS_RST;
    end else if (cfg_chan.valid) begin
      unique case (sacl_pkg::cfg_reg_t'(cfg_chan.index))
        sacl_pkg::REG_SET_BITS:    set_bits_r    <= cfg_chan.data[sacl_pkg::SET_BITS_W-1:0];
        sacl_pkg::REG_OFFSET_BITS: offset_bits_r <= cfg_chan.data;
        sacl_pkg::REG_WAYS:        ways_r        <= cfg_chan.data[sacl_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Address split.
  always_comb begin
    s_eff      = (set_bits_r > SET_CLAMP[sacl_pkg::SET_BITS_W-1:0]) ?
                 SET_CLAMP[sacl_pkg::SET_BITS_W-1:0] : set_bits_r;
    total_bits = TOTAL_W'(s_eff) + TOTAL_W'(offset_bits_r);
    tag_w      = (total_bits >= TOTAL_W'(sacl_pkg::ADDR_W)) ? '0 :
                 (in_chan.access_address >> total_bits);
    set_mask   = (sacl_pkg::ADDR_W'(1) << s_eff) - 1'b1;
    set_w      = SET_AW'((in_chan.access_address >> offset_bits_r) & set_mask);
    if (ways_r == '0) begin
      ways_eff = WCW'(1);
    end else if (WCW'(ways_r) > WCW'(MAX_WAYS)) begin
      ways_eff = WCW'(MAX_WAYS);
    end else begin
      ways_eff = WCW'(ways_r);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en_w[w] = (WCW'(w) < ways_eff);
    end
  end

  // Control sequencer.
  assign slot_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sacl_pkg::ST_CLEAR: if (clr_cnt_r == '1) state_nxt = sacl_pkg::ST_IDLE;
      sacl_pkg::ST_IDLE:  if (in_chan.valid) state_nxt = sacl_pkg::ST_LOOK;
      sacl_pkg::ST_LOOK:  state_nxt = sacl_pkg::ST_WRITE;
      sacl_pkg::ST_WRITE: if (slot_free) state_nxt = sacl_pkg::ST_IDLE;
      default:            state_nxt = sacl_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_take   = 1'b0;
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = new_row;
    unique case (state_r)
      sacl_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      sacl_pkg::ST_IDLE: begin
        in_take = 1'b1;
      end
      sacl_pkg::ST_WRITE: begin
        issue  = slot_free;
        ram_we = slot_free;
      end
      default: ;
    endcase
  end

  assign in_chan.ready = in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sacl_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sacl_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (in_take && in_chan.valid) begin
      set_r    <= set_w;
      tag_r    <= tag_w;
      way_en_r <= way_en_w;
    end
    if (state_r == sacl_pkg::ST_LOOK) begin
      outcome_r <= sel_outcome;
      sel_way_r <= sel_way;
      fresh_r   <= sel_fresh;
    end
  end

  sacl_ram #(
    .WIDTH  (ROW_W),
    .ADDR_W (SET_AW),
    .DEPTH  (DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_take && in_chan.valid),
    .raddr (set_w),
    .rdata (ram_rdata)
  );

  sacl_way_select #(
    .MAX_WAYS    (MAX_WAYS),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_way_select (
    .row     (ram_rdata),
    .tag     (tag_r),
    .way_en  (way_en_r),
    .outcome (sel_outcome),
    .sel_way (sel_way),
    .fresh   (sel_fresh)
  );

  // A hit line already holds the tag and is valid, so every outcome writes the same line.
  always_comb begin
    new_row = ram_rdata;
    new_row[sel_way_r*LINE_W +: LINE_W] = {1'b1, tag_r, fresh_r};
  end

  // Saturating totals.
  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    if (outcome_r == sacl_pkg::OUT_HIT) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + 1'b1;
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + 1'b1;
      if (outcome_r == sacl_pkg::OUT_EVICT && evict_cnt_r != '1) begin
        evict_cnt_nxt = evict_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_outcome_r <= outcome_r;
      out_hit_r     <= hit_cnt_nxt;
      out_miss_r    <= miss_cnt_nxt;
      out_evict_r   <= evict_cnt_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.outcome     = out_outcome_r;
  assign out_chan.hit_total   = out_hit_r;
  assign out_chan.miss_total  = out_miss_r;
  assign out_chan.evict_total = out_evict_r;

endmodule
